// File: rtl/pid_with_deadband_core_defines.svh
// ----------------------------------------------------------------------------
// pid_with_deadband_core_defines
// Assertion macros shared by the PID core; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PID_WITH_DEADBAND_CORE_DEFINES_SVH
`define PID_WITH_DEADBAND_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define PIDD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked out of reset
`define PIDD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define PIDD_ASSERT_IMP(label, ante, cons, msg)
`define PIDD_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/pidd_pkg.sv
// ----------------------------------------------------------------------------
// pidd_pkg
// Shared types and constants of the deadband PID core.
// ----------------------------------------------------------------------------
package pidd_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int DRIVE_W    = 32;
    localparam int SUM_W      = 32;
    localparam int DBAND_W    = 16;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_RST = 32'sh7FFF_FFFF;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_RST = 32'sh8000_0000;
    localparam logic signed [SUM_W-1:0]   SUM_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [SUM_W-1:0]   SUM_MIN       = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P   = 3'd0,
        CFG_GAIN_I   = 3'd1,
        CFG_GAIN_D   = 3'd2,
        CFG_DEADBAND = 3'd3,
        CFG_DRV_MAX  = 3'd4,
        CFG_DRV_MIN  = 3'd5,
        CFG_FALLBACK = 3'd6
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_INVALID   = 3'd0,
        ST_PRIMED    = 3'd1,
        ST_UPDATED   = 3'd2,
        ST_HELD      = 3'd3,
        ST_RESTARTED = 3'd4
    } t_step_status;

    // per-step control result from the datapath
    typedef struct packed {
        logic         last_known;
        t_step_status status;
    } t_step_ctl;

endpackage

// File: rtl/pid_with_deadband_core.sv
// ----------------------------------------------------------------------------
// pid_with_deadband_core
// Discrete PID controller with deadband, output clamp and fallback drive.
// ----------------------------------------------------------------------------
// Each accepted item is one sample (restart, measured + valid flag, target)
// and yields exactly one result (drive value, step status). The block takes
// one item per clock while the result output is not stalled. A taken item
// waits in the input register until the result register is free; its result
// is then loaded into the result register and offered at the output. The
// one-item-per-clock rate is set by the PID stage (three multiplies, a
// full-width sum and the clamp), which is combinational since each step
// needs the error sum and last error that the previous step leaves. A
// stalled result holds the input register, and the input stalls only
// while both registers are full and the result output is stalled. The
// error is target - measured. Restart clears
// the error sum and forgets the last error; an invalid sample forgets the
// last error and outputs the fallback drive; an error whose magnitude is
// below the deadband holds everything; the first valid error outside the
// band only primes the loop and outputs the fallback. Otherwise the drive is
// P*e + I*(old sum) + D*(e - last e), clamped to [drive_min, drive_max]
// before it is cut to 32 bits, and the sum adds e with 32-bit saturation.
// Write configuration only while no items are in flight; the port is always
// ready, and an index past the fallback register is ignored.
// ----------------------------------------------------------------------------
`include "pid_with_deadband_core_defines.svh"

module pid_with_deadband_core #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int GAIN_WIDTH   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_restart,
    input  logic [SAMPLE_WIDTH-1:0]             i_measured,
    input  logic                                i_measured_valid,
    input  logic [SAMPLE_WIDTH-1:0]             i_target,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [pidd_pkg::DRIVE_W-1:0] o_drive_value,
    output logic [2:0]                          o_step_status,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pidd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pidd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration
    logic signed [GAIN_WIDTH-1:0]        gain_p, gain_i, gain_d;
    logic [pidd_pkg::DBAND_W-1:0]        deadband;
    logic signed [pidd_pkg::DRIVE_W-1:0] drive_max, drive_min, fallback;

    // input register
    logic                      r_s1_valid;
    logic                      r_s1_restart;
    logic [SAMPLE_WIDTH-1:0]   r_s1_measured;
    logic                      r_s1_meas_valid;
    logic [SAMPLE_WIDTH-1:0]   r_s1_target;

    // result register and loop state; the drive register is the output
    logic                                r_out_valid;
    pidd_pkg::t_step_status              r_status;
    logic signed [pidd_pkg::SUM_W-1:0]   r_error_sum;
    logic signed [SAMPLE_WIDTH:0]        r_last_error;
    logic                                r_last_known;
    logic signed [pidd_pkg::DRIVE_W-1:0] r_drive;

    logic signed [pidd_pkg::SUM_W-1:0]   n_error_sum;
    logic signed [SAMPLE_WIDTH:0]        n_last_error;
    logic signed [pidd_pkg::DRIVE_W-1:0] n_drive;
    pidd_pkg::t_step_ctl                 step_ctl;

    logic out_free;   // result register can load this cycle
    logic s1_fire;    // input register item leaves as its result is loaded
    logic in_fire;

    assign o_cfg_ready = 1'b1;

    pidd_cfg #(
        .GAIN_WIDTH (GAIN_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (i_cfg_valid && o_cfg_ready),
        .i_index     (i_cfg_index),
        .i_data      (i_cfg_data),
        .o_gain_p    (gain_p),
        .o_gain_i    (gain_i),
        .o_gain_d    (gain_d),
        .o_deadband  (deadband),
        .o_drive_max (drive_max),
        .o_drive_min (drive_min),
        .o_fallback  (fallback)
    );

    // two-stage valid/stall pipeline, one item per cycle when unstalled
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_restart    <= i_restart;
            r_s1_measured   <= i_measured;
            r_s1_meas_valid <= i_measured_valid;
            r_s1_target     <= i_target;
        end
    end

    pidd_calc #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .GAIN_WIDTH   (GAIN_WIDTH)
    ) u_calc (
        .i_restart        (r_s1_restart),
        .i_measured       (r_s1_measured),
        .i_measured_valid (r_s1_meas_valid),
        .i_target         (r_s1_target),
        .i_gain_p         (gain_p),
        .i_gain_i         (gain_i),
        .i_gain_d         (gain_d),
        .i_deadband       (deadband),
        .i_drive_max      (drive_max),
        .i_drive_min      (drive_min),
        .i_fallback       (fallback),
        .i_error_sum      (r_error_sum),
        .i_last_error     (r_last_error),
        .i_last_known     (r_last_known),
        .i_drive          (r_drive),
        .o_error_sum      (n_error_sum),
        .o_last_error     (n_last_error),
        .o_drive          (n_drive),
        .o_ctl            (step_ctl)
    );

    // loop state commits together with the result it produced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_error_sum  <= '0;
            r_last_error <= '0;
            r_last_known <= 1'b0;
            r_drive      <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                r_error_sum  <= n_error_sum;
                r_last_error <= n_last_error;
                r_last_known <= step_ctl.last_known;
                r_drive      <= n_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_status <= step_ctl.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_value = r_drive;
    assign o_step_status = r_status;

    // restart result: sum cleared and last error forgotten
    `PIDD_ASSERT_IMP(a_restart_clears, r_out_valid && r_status == pidd_pkg::ST_RESTARTED, r_error_sum == '0 && !r_last_known, "restart did not clear loop state")
    // last-error flag tracks the status of the newest result
    `PIDD_ASSERT_IMP(a_known_flag, r_out_valid && (r_status == pidd_pkg::ST_PRIMED || r_status == pidd_pkg::ST_UPDATED), r_last_known, "last error not marked known")
    // an updated drive lies within ordered limits
    `PIDD_ASSERT_IMP(a_clamp_range, r_out_valid && r_status == pidd_pkg::ST_UPDATED && drive_min <= drive_max, r_drive <= drive_max && r_drive >= drive_min, "drive outside clamp limits")
    // an invalid sample leads to the fallback drive
    `PIDD_ASSERT_NXT(a_invalid_fallback, s1_fire && !r_s1_restart && !r_s1_meas_valid, r_drive == $past(fallback) && !r_last_known, "invalid sample did not select fallback")

endmodule

// File: rtl/pidd_cfg.sv
// ----------------------------------------------------------------------------
// pidd_cfg
// Configuration register file: gains, deadband, clamp limits, fallback.
// ----------------------------------------------------------------------------
module pidd_cfg #(
    parameter int GAIN_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_wr_en,
    input  logic [pidd_pkg::CFG_IDX_W-1:0]         i_index,
    input  logic [pidd_pkg::CFG_DATA_W-1:0]        i_data,
    output logic signed [GAIN_WIDTH-1:0]           o_gain_p,
    output logic signed [GAIN_WIDTH-1:0]           o_gain_i,
    output logic signed [GAIN_WIDTH-1:0]           o_gain_d,
    output logic [pidd_pkg::DBAND_W-1:0]           o_deadband,
    output logic signed [pidd_pkg::DRIVE_W-1:0]    o_drive_max,
    output logic signed [pidd_pkg::DRIVE_W-1:0]    o_drive_min,
    output logic signed [pidd_pkg::DRIVE_W-1:0]    o_fallback
);

    logic signed [GAIN_WIDTH-1:0]        r_gain_p, r_gain_i, r_gain_d;
    logic [pidd_pkg::DBAND_W-1:0]        r_deadband;
    logic signed [pidd_pkg::DRIVE_W-1:0] r_drive_max, r_drive_min, r_fallback;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_deadband  <= '0;
            r_drive_max <= pidd_pkg::DRIVE_MAX_RST;
            r_drive_min <= pidd_pkg::DRIVE_MIN_RST;
            r_fallback  <= '0;
        end else if (i_wr_en) begin
            unique case (pidd_pkg::t_cfg_index'(i_index))
                pidd_pkg::CFG_GAIN_P:   r_gain_p    <= $signed(i_data[GAIN_WIDTH-1:0]);
                pidd_pkg::CFG_GAIN_I:   r_gain_i    <= $signed(i_data[GAIN_WIDTH-1:0]);
                pidd_pkg::CFG_GAIN_D:   r_gain_d    <= $signed(i_data[GAIN_WIDTH-1:0]);
                pidd_pkg::CFG_DEADBAND: r_deadband  <= i_data[pidd_pkg::DBAND_W-1:0];
                pidd_pkg::CFG_DRV_MAX:  r_drive_max <= $signed(i_data[pidd_pkg::DRIVE_W-1:0]);
                pidd_pkg::CFG_DRV_MIN:  r_drive_min <= $signed(i_data[pidd_pkg::DRIVE_W-1:0]);
                pidd_pkg::CFG_FALLBACK: r_fallback  <= $signed(i_data[pidd_pkg::DRIVE_W-1:0]);
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    assign o_gain_p    = r_gain_p;
    assign o_gain_i    = r_gain_i;
    assign o_gain_d    = r_gain_d;
    assign o_deadband  = r_deadband;
    assign o_drive_max = r_drive_max;
    assign o_drive_min = r_drive_min;
    assign o_fallback  = r_fallback;

endmodule

// File: rtl/pidd_calc.sv
// ----------------------------------------------------------------------------
// pidd_calc
// One PID step: error, deadband test, three products, clamp, sum update.
// ----------------------------------------------------------------------------
module pidd_calc #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int GAIN_WIDTH   = 16
) (
    input  logic                                 i_restart,
    input  logic [SAMPLE_WIDTH-1:0]              i_measured,
    input  logic                                 i_measured_valid,
    input  logic [SAMPLE_WIDTH-1:0]              i_target,
    input  logic signed [GAIN_WIDTH-1:0]         i_gain_p,
    input  logic signed [GAIN_WIDTH-1:0]         i_gain_i,
    input  logic signed [GAIN_WIDTH-1:0]         i_gain_d,
    input  logic [pidd_pkg::DBAND_W-1:0]         i_deadband,
    input  logic signed [pidd_pkg::DRIVE_W-1:0]  i_drive_max,
    input  logic signed [pidd_pkg::DRIVE_W-1:0]  i_drive_min,
    input  logic signed [pidd_pkg::DRIVE_W-1:0]  i_fallback,
    input  logic signed [pidd_pkg::SUM_W-1:0]    i_error_sum,
    input  logic signed [SAMPLE_WIDTH:0]         i_last_error,
    input  logic                                 i_last_known,
    input  logic signed [pidd_pkg::DRIVE_W-1:0]  i_drive,
    output logic signed [pidd_pkg::SUM_W-1:0]    o_error_sum,
    output logic signed [SAMPLE_WIDTH:0]         o_last_error,
    output logic signed [pidd_pkg::DRIVE_W-1:0]  o_drive,
    output pidd_pkg::t_step_ctl                  o_ctl
);

    localparam int EW = SAMPLE_WIDTH + 1;                    // error
    localparam int DW = SAMPLE_WIDTH + 2;                    // error delta
    localparam int MW = (EW > pidd_pkg::DBAND_W) ? EW : pidd_pkg::DBAND_W;
    localparam int XW = (DW > pidd_pkg::SUM_W) ? DW : pidd_pkg::SUM_W;
    localparam int AW = GAIN_WIDTH + XW + 2;                 // exact sum, no wrap
    localparam int PW  = GAIN_WIDTH + EW;                    // P product
    localparam int IW  = GAIN_WIDTH + pidd_pkg::SUM_W;       // I product
    localparam int DPW = GAIN_WIDTH + DW;                    // D product

    logic signed [EW-1:0]               e;
    logic [EW-1:0]                      e_mag;
    logic                               in_band;
    logic signed [DW-1:0]               de;
    logic signed [GAIN_WIDTH+EW-1:0]    prod_p;
    logic signed [GAIN_WIDTH+pidd_pkg::SUM_W-1:0] prod_i;
    logic signed [GAIN_WIDTH+DW-1:0]    prod_d;
    logic signed [AW-1:0]               acc;
    logic signed [pidd_pkg::DRIVE_W-1:0] clamped;
    logic signed [pidd_pkg::SUM_W:0]    sum_x;
    logic signed [pidd_pkg::SUM_W-1:0]  sum_sat;

    assign e       = $signed({1'b0, i_target}) - $signed({1'b0, i_measured});
    assign e_mag   = e[EW-1] ? EW'(-e) : EW'(e);
    assign in_band = MW'(e_mag) < MW'(i_deadband);
    assign de      = $signed({e[EW-1], e}) - $signed({i_last_error[EW-1], i_last_error});

    assign prod_p = PW'(i_gain_p) * PW'(e);
    assign prod_i = IW'(i_gain_i) * IW'(i_error_sum);
    assign prod_d = DPW'(i_gain_d) * DPW'(de);
    assign acc    = AW'(prod_p) + AW'(prod_i) + AW'(prod_d);

    // clamp on the full-width sum; the upper limit is checked first
    always_comb begin
        if (acc > AW'(i_drive_max)) begin
            clamped = i_drive_max;
        end else if (acc < AW'(i_drive_min)) begin
            clamped = i_drive_min;
        end else begin
            clamped = acc[pidd_pkg::DRIVE_W-1:0];
        end
    end

    assign sum_x = (pidd_pkg::SUM_W+1)'(i_error_sum) + (pidd_pkg::SUM_W+1)'(e);

    always_comb begin
        if (sum_x[pidd_pkg::SUM_W] != sum_x[pidd_pkg::SUM_W-1]) begin
            sum_sat = sum_x[pidd_pkg::SUM_W] ? pidd_pkg::SUM_MIN : pidd_pkg::SUM_MAX;
        end else begin
            sum_sat = sum_x[pidd_pkg::SUM_W-1:0];
        end
    end

    always_comb begin
        o_error_sum    = i_error_sum;
        o_last_error   = i_last_error;
        o_drive        = i_drive;
        o_ctl.last_known = i_last_known;
        o_ctl.status   = pidd_pkg::ST_HELD;
        if (i_restart) begin
            o_error_sum      = '0;
            o_last_error     = '0;
            o_ctl.last_known = 1'b0;
            o_ctl.status     = pidd_pkg::ST_RESTARTED;
        end else if (!i_measured_valid) begin
            o_ctl.last_known = 1'b0;
            o_drive          = i_fallback;
            o_ctl.status     = pidd_pkg::ST_INVALID;
        end else if (in_band) begin
            o_ctl.status     = pidd_pkg::ST_HELD;
        end else if (!i_last_known) begin
            o_last_error     = e;
            o_ctl.last_known = 1'b1;
            o_drive          = i_fallback;
            o_ctl.status     = pidd_pkg::ST_PRIMED;
        end else begin
            o_last_error     = e;
            o_error_sum      = sum_sat;
            o_drive          = clamped;
            o_ctl.status     = pidd_pkg::ST_UPDATED;
        end
    end

endmodule
